// ===== design/sm3_pkg.sv =====
// Shared widths and exponential tables for the three-class softmax unit.
package sm3_pkg;

   localparam int NumFields    = 3;
   localparam int NumLogitsDef = 3;
   localparam int LogitW       = 16;
   localparam int ExpW         = 17;   // Q1.16, 1.0 = 65536
   localparam int SumW         = 19;
   localparam int ProbW        = 16;
   localparam int QuotW        = 17;
   localparam int IntTableLen  = 12;

   typedef logic [ExpW-1:0] exp_type;

   function automatic exp_type exp_int(input logic [3:0] idx);
      exp_type v;
      case (idx)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd24109;
         4'd2:  v = 17'd8869;
         4'd3:  v = 17'd3263;
         4'd4:  v = 17'd1200;
         4'd5:  v = 17'd442;
         4'd6:  v = 17'd162;
         4'd7:  v = 17'd60;
         4'd8:  v = 17'd22;
         4'd9:  v = 17'd8;
         4'd10: v = 17'd3;
         4'd11: v = 17'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic exp_type exp_hi(input logic [3:0] idx);
      exp_type v;
      case (idx)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd61565;
         4'd2:  v = 17'd57835;
         4'd3:  v = 17'd54331;
         4'd4:  v = 17'd51039;
         4'd5:  v = 17'd47947;
         4'd6:  v = 17'd45042;
         4'd7:  v = 17'd42313;
         4'd8:  v = 17'd39750;
         4'd9:  v = 17'd37341;
         4'd10: v = 17'd35079;
         4'd11: v = 17'd32954;
         4'd12: v = 17'd30957;
         4'd13: v = 17'd29081;
         4'd14: v = 17'd27319;
         default: v = 17'd25664;
      endcase
      return v;
   endfunction

   function automatic exp_type exp_lo(input logic [3:0] idx);
      exp_type v;
      case (idx)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd65280;
         4'd2:  v = 17'd65026;
         4'd3:  v = 17'd64772;
         4'd4:  v = 17'd64520;
         4'd5:  v = 17'd64268;
         4'd6:  v = 17'd64018;
         4'd7:  v = 17'd63768;
         4'd8:  v = 17'd63520;
         4'd9:  v = 17'd63272;
         4'd10: v = 17'd63025;
         4'd11: v = 17'd62780;
         4'd12: v = 17'd62535;
         4'd13: v = 17'd62291;
         4'd14: v = 17'd62048;
         default: v = 17'd61806;
      endcase
      return v;
   endfunction

endpackage

// ===== design/sm3_exp_lane.sv =====
// Exponential lane: exp(-a) for a Q8.8 distance, two pipeline stages.
module sm3_exp_lane
   import sm3_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [LogitW-1:0] gap,
   output exp_type           e
);

   logic [2*ExpW-1:0] p1_ff, p1_in;
   logic [3:0]        lo_ff;
   exp_type           e_ff, e_in;
   exp_type           e0, r1;
   logic [2*ExpW-1:0] p2;

   always_comb begin
      e0 = (gap[15:8] >= 8'(IntTableLen)) ? '0 : exp_int(gap[11:8]);
      p1_in = e0 * exp_hi(gap[7:4]);
      r1 = ExpW'((p1_ff + 34'd32768) >> 16);
      p2 = r1 * exp_lo(lo_ff);
      e_in = ExpW'((p2 + 34'd32768) >> 16);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         lo_ff <= gap[3:0];
         e_ff  <= e_in;
      end
   end

   assign e = e_ff;

endmodule

// ===== design/sm3_div_lane.sv =====
// Pipelined restoring divider: round(e * 65536 / sum), one quotient bit per stage.
module sm3_div_lane
   import sm3_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  exp_type          e,
   input  logic [SumW-1:0]  sum,
   output logic [QuotW-1:0] quot
);

   localparam int NumW = ExpW + 17;

   logic [SumW-1:0]  rem_ff [QuotW];
   logic [QuotW-1:0] low_ff [QuotW];
   logic [QuotW-1:0] q_ff   [QuotW];
   logic [SumW-1:0]  den_ff [QuotW];

   logic [NumW-1:0] num;
   assign num = NumW'({e, 16'd0}) + NumW'(sum >> 1);

   for (genvar j = 0; j < QuotW; j++) begin : g_stage
      logic [SumW-1:0]  rem_i, den_i;
      logic [QuotW-1:0] low_i, q_i;
      logic [SumW:0]    t;
      logic             ge;
      if (j == 0) begin : g_first
         assign rem_i = SumW'(num[NumW-1:QuotW]);
         assign low_i = num[QuotW-1:0];
         assign q_i   = '0;
         assign den_i = sum;
      end else begin : g_next
         assign rem_i = rem_ff[j-1];
         assign low_i = low_ff[j-1];
         assign q_i   = q_ff[j-1];
         assign den_i = den_ff[j-1];
      end
      assign t  = {rem_i, low_i[QuotW-1]};
      assign ge = t >= {1'b0, den_i};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? SumW'(t - {1'b0, den_i}) : SumW'(t);
            low_ff[j] <= {low_i[QuotW-2:0], 1'b0};
            q_ff[j]   <= {q_i[QuotW-2:0], ge};
            den_ff[j] <= den_i;
         end
      end
   end

   assign quot = q_ff[QuotW-1];

endmodule

// ===== design/softmax_three_class_unit.sv =====
// Top level of the three-class softmax unit.
//   channel | ports                                      | direction
//   req     | req_valid req_stall req_logit_*             | in
//   rsp     | rsp_valid rsp_stall rsp_prob_* rsp_predicted_class | out
// Fully pipelined: one item per cycle while rsp_stall does not hold the output; stages are
// input reg, max, two exp stages, sum, 17 divider stages, output reg.
// Reset clears only the valid bits. The pipeline freezes only while an item
// waits at the output under rsp_stall; empty slots move along, never squeezed out.
module softmax_three_class_unit
   import sm3_pkg::*;
#(
   parameter int NUM_LOGITS = NumLogitsDef
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [LogitW-1:0] req_logit_0,
   input  logic signed [LogitW-1:0] req_logit_1,
   input  logic signed [LogitW-1:0] req_logit_2,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ProbW-1:0]         rsp_prob_0,
   output logic [ProbW-1:0]         rsp_prob_1,
   output logic [ProbW-1:0]         rsp_prob_2,
   output logic                     rsp_predicted_class
);

   localparam int Active = (NUM_LOGITS < 1) ? 1 :
                           ((NUM_LOGITS > NumFields) ? NumFields : NUM_LOGITS);
   localparam int Latency = 5 + QuotW + 1;

   logic en;
   logic [Latency-1:0] vld_ff;

   assign en        = !(vld_ff[Latency-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[Latency-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Latency-2:0], req_valid};
      end
   end

   logic signed [LogitW-1:0] lg_ff [NumFields];
   always_ff @(posedge clock) begin
      if (en) begin
         lg_ff[0] <= req_logit_0;
         lg_ff[1] <= req_logit_1;
         lg_ff[2] <= req_logit_2;
      end
   end

   // maximum over active classes, then distances
   logic signed [LogitW-1:0] mx;
   logic [LogitW-1:0]        dist_ff [NumFields];
   always_comb begin
      mx = lg_ff[0];
      for (int k = 1; k < Active; k++) begin
         if (lg_ff[k] > mx) mx = lg_ff[k];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NumFields; k++) begin
            dist_ff[k] <= LogitW'(17'(mx) - 17'(lg_ff[k]));
         end
      end
   end

   exp_type          ex      [NumFields];
   exp_type          ex_ff   [NumFields];
   logic [SumW-1:0]  sum_ff, sum_in;
   logic [QuotW-1:0] quot    [NumFields];

   for (genvar k = 0; k < NumFields; k++) begin : g_lane
      sm3_exp_lane u_exp (
         .clock (clock),
         .en    (en),
         .gap   (dist_ff[k]),
         .e     (ex[k])
      );
      sm3_div_lane u_div (
         .clock (clock),
         .en    (en),
         .e     (ex_ff[k]),
         .sum   (sum_ff),
         .quot  (quot[k])
      );
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < Active; k++) begin
         sum_in = sum_in + SumW'(ex[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
         for (int k = 0; k < NumFields; k++) begin
            ex_ff[k] <= (k < Active) ? ex[k] : '0;
         end
      end
   end

   logic [ProbW-1:0] p_ff [NumFields];
   logic [ProbW-1:0] p_in [NumFields];
   logic             pred_ff;
   always_comb begin
      for (int k = 0; k < NumFields; k++) begin
         p_in[k] = quot[k][QuotW-1] ? '1 : quot[k][ProbW-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NumFields; k++) p_ff[k] <= p_in[k];
         pred_ff <= p_in[1] > p_in[0];
      end
   end

   assign rsp_prob_0          = p_ff[0];
   assign rsp_prob_1          = p_ff[1];
   assign rsp_prob_2          = p_ff[2];
   assign rsp_predicted_class = pred_ff;

endmodule

// ===== bench/tb_softmax_three_class_unit.sv =====
// Self-checking testbench for the three-class softmax unit.
`timescale 1ns / 100ps

module tb_softmax_three_class_unit;
   import sm3_pkg::*;

   typedef struct packed {
      logic signed [LogitW-1:0] l0;
      logic signed [LogitW-1:0] l1;
      logic signed [LogitW-1:0] l2;
   } logits_type;

   typedef struct packed {
      logic [ProbW-1:0] p0;
      logic [ProbW-1:0] p1;
      logic [ProbW-1:0] p2;
      logic             cls;
   } probs_type;

   localparam int ActiveCount = (NumLogitsDef < 1) ? 1 :
                                (NumLogitsDef > NumFields ? NumFields : NumLogitsDef);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [LogitW-1:0] req_logit_0 = '0;
   logic signed [LogitW-1:0] req_logit_1 = '0;
   logic signed [LogitW-1:0] req_logit_2 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ProbW-1:0] rsp_prob_0, rsp_prob_1, rsp_prob_2;
   logic rsp_predicted_class;
   logic req_stall_q = 1'b0;

   logits_type pending_logits[$];
   probs_type  expected_probs[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      hold_start = 0;
   bit      hold_on = 0;
   bit      stim_done = 0;
   int      errors = 0;

   softmax_three_class_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exp(-a/256) in Q1.16 using the three-table product
   function automatic longint unsigned exp_of_distance(input logic [15:0] a);
      longint unsigned e;
      if (a[15:8] >= IntTableLen) return 0;
      e = 64'(exp_int(a[11:8]));
      e = (e * 64'(exp_hi(a[7:4])) + 32768) >> 16;
      e = (e * 64'(exp_lo(a[3:0])) + 32768) >> 16;
      return e;
   endfunction

   function automatic probs_type softmax_of(input logits_type x);
      int signed v[NumFields];
      longint unsigned e[NumFields];
      longint unsigned q[NumFields];
      longint unsigned sum;
      int signed mx;
      probs_type r;
      v[0] = x.l0; v[1] = x.l1; v[2] = x.l2;
      mx = v[0];
      for (int k = 1; k < ActiveCount; k++) if (v[k] > mx) mx = v[k];
      sum = 0;
      for (int k = 0; k < NumFields; k++) begin
         e[k] = (k < ActiveCount) ? exp_of_distance(16'(mx - v[k])) : 0;
         sum += e[k];
      end
      for (int k = 0; k < NumFields; k++) begin
         q[k] = (sum != 0) ? (e[k] * 65536 + sum / 2) / sum : 0;
         if (q[k] > 65535) q[k] = 65535;
      end
      r.p0 = q[0][15:0]; r.p1 = q[1][15:0]; r.p2 = q[2][15:0];
      r.cls = q[1] > q[0];
      return r;
   endfunction

   // driver: new item offered on the falling edge after acceptance or idle
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall_q) begin
            if (pending_logits.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               logits_type it;
               it = pending_logits.pop_front();
               req_logit_0 <= it.l0;
               req_logit_1 <= it.l1;
               req_logit_2 <= it.l2;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (hold_on)
            rsp_stall <= 1'b1;
         else
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // long receiver hold-off, counted in cycles
   initial begin
      wait (hold_start);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (200) @(posedge clock);
      hold_on = 1'b0;
   end

   // stall as seen at the last rising edge, so the driver knows if the item moved
   always @(posedge clock) begin
      req_stall_q <= req_stall;
      if (!reset && req_valid && !req_stall)
         expected_probs.push_back(softmax_of({req_logit_0, req_logit_1, req_logit_2}));
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_probs.size() == 0) begin
            $error("result with no item pending");
            errors++;
         end else begin
            probs_type ex;
            ex = expected_probs.pop_front();
            if (rsp_prob_0 !== ex.p0) begin
               $error("prob_0 expected %0d got %0d", ex.p0, rsp_prob_0); errors++;
            end
            if (rsp_prob_1 !== ex.p1) begin
               $error("prob_1 expected %0d got %0d", ex.p1, rsp_prob_1); errors++;
            end
            if (rsp_prob_2 !== ex.p2) begin
               $error("prob_2 expected %0d got %0d", ex.p2, rsp_prob_2); errors++;
            end
            if (rsp_predicted_class !== ex.cls) begin
               $error("predicted_class expected %0d got %0d", ex.cls,
                      rsp_predicted_class);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [15:0] rand_logit();
      int sel;
      sel = $urandom_range(3);
      if (sel == 0) return 16'($urandom);
      return 16'($signed($urandom_range(4095)) - 2048);
   endfunction

   task automatic push(input int a, input int b, input int c);
      logits_type it;
      it.l0 = 16'(a); it.l1 = 16'(b); it.l2 = 16'(c);
      pending_logits.push_back(it);
   endtask

   task automatic drain();
      while (pending_logits.size() > 0 || req_valid) @(posedge clock);
   endtask

   task automatic random_phase(input int n, input int idle, input int stall);
      int base;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         base = 16'(rand_logit());
         // mostly logits near one another, so the tables are exercised
         if ($urandom_range(3) != 0)
            push(base, base + $signed($urandom_range(1023)) - 512,
                 base + $signed($urandom_range(3071)) - 1536);
         else
            push(rand_logit(), rand_logit(), rand_logit());
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed corners
      push(0, 0, 0);
      push(32767, 32767, 32767);
      push(-32768, -32768, -32768);
      push(32767, -32768, 0);
      push(-32768, 32767, 0);
      push(-32768, 0, 32767);
      push(3072, 0, 0);
      push(0, 3072, 0);
      push(0, 0, 3071);
      push(256, 256, 0);
      push(0, 256, 256);
      push(100, 99, 100);
      push(-1, 0, -1);
      push(0, 4095, 15);
      push(16'h5555, 16'haaaa, 16'h00ff);
      push(16'haaaa, 16'h5555, 16'hff00);
      drain();
      random_phase(150, 0, 0);
      random_phase(130, 78, 0);
      random_phase(130, 0, 78);
      random_phase(130, 37, 37);
      // long hold-off while items keep coming, so the pipeline backs up
      @(negedge clock);
      hold_start = 1'b1;
      random_phase(160, 0, 0);
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (expected_probs.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_probs.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
